// ===== design/dpss_pkg.sv =====
// shared types, codes and time helpers for the day plan schedule selector
package dpss_pkg;

    localparam int MIN_PER_HOUR = 60;
    localparam int DAY_MINUTES  = 1440;

    localparam int SCHED_W = 64;
    localparam int SLOT_W  = 19;
    localparam int ACT_W   = 8;
    localparam int TIME_W  = 11;

    typedef enum logic [1:0] {
        OP_SCHED_WR = 2'd0,
        OP_SLOT_WR  = 2'd1,
        OP_ACT_WR   = 2'd2,
        OP_QUERY    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_MATCH   = 2'd1,
        STAT_PLAN_EMPTY = 2'd2,
        STAT_BAD_ACTION = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCHED,
        S_SLOT,
        S_ACT,
        S_ACT_DATA,
        S_RESULT
    } state_t;

    // controls from the sequencer into the slot evaluator
    typedef struct packed {
        logic clear;
        logic rd_valid;
        logic rd_last;
    } slot_ctl_t;

    // running pick reported back to the sequencer
    typedef struct packed {
        logic              done;
        logic              any;
        logic [ACT_W-1:0]  best_act;
        logic [TIME_W-1:0] best_gap;
    } slot_res_t;

    // hour and minute to minute of day, one wrap at most
    function automatic logic [TIME_W-1:0] minute_of_day(input logic [4:0] h,
                                                        input logic [5:0] m);
        logic [11:0] t;
        t = 12'(h) * 12'(MIN_PER_HOUR) + 12'(m);
        if (t >= 12'(DAY_MINUTES))
        begin
            t = t - 12'(DAY_MINUTES);
        end
        return t[TIME_W-1:0];
    endfunction

endpackage

// ===== design/dpss_ram.sv =====
// generic single-write, single-read ram with registered read data
module dpss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/dpss_slot_pick.sv =====
// two-stage slot evaluator: start time, then gap and best-slot tracking
module dpss_slot_pick
    import dpss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  slot_ctl_t         ctl,
    input  logic [SLOT_W-1:0] rd_data,
    input  logic [TIME_W-1:0] now,
    output slot_res_t         res
);

    logic              a_valid_reg, a_valid_next;
    logic              a_last_reg, a_last_next;
    logic [ACT_W-1:0]  a_act_reg;
    logic [TIME_W-1:0] a_start_reg;

    logic              any_reg, any_next;
    logic              done_reg, done_next;
    logic [ACT_W-1:0]  best_act_reg, best_act_next;
    logic [TIME_W-1:0] best_gap_reg, best_gap_next;

    logic [11:0]       gap_wide;
    logic [TIME_W-1:0] gap;

    // stage a: unused slots drop out here
    assign a_valid_next = ctl.rd_valid && (rd_data[18:11] != '0);
    assign a_last_next  = ctl.rd_valid && ctl.rd_last;

    always_ff @(posedge clk)
    begin
        a_act_reg   <= rd_data[18:11];
        a_start_reg <= minute_of_day(rd_data[10:6], rd_data[5:0]);
    end

    // stage b: gap with day wrap, exact match goes to the latest slot
    always_comb
    begin
        if (now >= a_start_reg)
        begin
            gap_wide = 12'(now) - 12'(a_start_reg);
        end
        else
        begin
            gap_wide = 12'(now) + 12'(DAY_MINUTES) - 12'(a_start_reg);
        end
        gap = gap_wide[TIME_W-1:0];

        any_next      = any_reg;
        best_act_next = best_act_reg;
        best_gap_next = best_gap_reg;
        done_next     = a_last_reg;
        if (ctl.clear)
        begin
            any_next      = 1'b0;
            best_act_next = '0;
            best_gap_next = '0;
            done_next     = 1'b0;
        end
        else if (a_valid_reg)
        begin
            any_next = 1'b1;
            if (gap == '0 || !any_reg || gap < best_gap_reg)
            begin
                best_act_next = a_act_reg;
                best_gap_next = gap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            any_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            a_last_reg  <= a_last_next;
            any_reg     <= any_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_act_reg <= best_act_next;
        best_gap_reg <= best_gap_next;
    end

    // done, any, best action, best gap
    assign res = {done_reg, any_reg, best_act_reg, best_gap_reg};

endmodule

// ===== design/day_plan_schedule_selector.sv =====
// day plan schedule selector: table loading, schedule match and slot pick
// a write word goes through S_RESULT to the output register; a query scans the schedule
//   entries and then the plan slots, so its time is set by the serial scans
// flow: one word at a time; a new word is taken while the last response waits
// reset: cmd_ready low for a clearing pass of the deepest memory
module day_plan_schedule_selector
    import dpss_pkg::*;
#(
    parameter int SCHEDULE_ENTRIES = 32,
    parameter int DAY_PLANS        = 16,
    parameter int SLOTS_PER_PLAN   = 32,
    parameter int ACTION_COUNT     = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    // command channel: table writes and queries
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  entry_index,
    input  logic [3:0]  table_index,
    input  logic [15:0] month_mask,
    input  logic [31:0] day_mask,
    input  logic [7:0]  week_mask,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [7:0]  id_value,
    input  logic [3:0]  month,
    input  logic [4:0]  day_of_month,
    input  logic [2:0]  weekday,
    // response channel
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  status,
    output logic [7:0]  scheme_id,
    output logic [4:0]  plan_id,
    output logic [7:0]  action_id,
    output logic [10:0] gap_minutes
);

    localparam int SLOT_DEPTH = DAY_PLANS * SLOTS_PER_PLAN;
    localparam int CLEAR_LEN0 = (SCHEDULE_ENTRIES > SLOT_DEPTH) ? SCHEDULE_ENTRIES : SLOT_DEPTH;
    localparam int CLEAR_LEN  = (CLEAR_LEN0 > ACTION_COUNT) ? CLEAR_LEN0 : ACTION_COUNT;

    localparam int SAW = (SCHEDULE_ENTRIES > 1) ? $clog2(SCHEDULE_ENTRIES) : 1;
    localparam int LAW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int AAW = (ACTION_COUNT > 1) ? $clog2(ACTION_COUNT) : 1;
    localparam int CW  = $clog2(CLEAR_LEN + 1);
    localparam int SCW = $clog2(SCHEDULE_ENTRIES + 1);
    localparam int SLW = $clog2(SLOTS_PER_PLAN + 1);

    // sequencer state
    state_t            state_reg, state_next;
    logic [CW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [SCW-1:0]    sch_cnt_reg, sch_cnt_next;
    logic              sch_pend_reg, sch_pend_next;
    logic              sch_last_reg, sch_last_next;
    logic [SLW-1:0]    slot_cnt_reg, slot_cnt_next;
    logic              slot_pend_reg, slot_pend_next;
    logic              slot_last_reg, slot_last_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              out_load;

    // query fields and working values
    logic [LAW-1:0]    base_reg, base_next;
    logic [3:0]        q_month_reg, q_month_next;
    logic [4:0]        q_mday_reg, q_mday_next;
    logic [2:0]        q_wday_reg, q_wday_next;
    logic [TIME_W-1:0] now_reg, now_next;

    // response being built, and the output word
    logic [1:0]        res_status_reg, res_status_next;
    logic [7:0]        res_scheme_reg, res_scheme_next;
    logic [4:0]        res_plan_reg, res_plan_next;
    logic [7:0]        res_action_reg, res_action_next;
    logic [10:0]       res_gap_reg, res_gap_next;
    logic [1:0]        status_reg;
    logic [7:0]        scheme_reg;
    logic [4:0]        plan_reg;
    logic [7:0]        action_reg;
    logic [10:0]       gap_reg;

    // memory ports
    logic               sch_we, sch_re;
    logic [SAW-1:0]     sch_waddr, sch_raddr;
    logic [SCHED_W-1:0] sch_wdata, sch_rdata;
    logic               slot_we, slot_re;
    logic [LAW-1:0]     slot_waddr, slot_raddr;
    logic [SLOT_W-1:0]  slot_wdata, slot_rdata;
    logic               act_we, act_re;
    logic [AAW-1:0]     act_waddr, act_raddr;
    logic [ACT_W-1:0]   act_wdata, act_rdata;

    slot_ctl_t          slot_ctl;
    slot_res_t          slot_res;

    // schedule match on the entry read back this cycle
    logic [15:0] mon_bits;
    logic [31:0] day_bits;
    logic [7:0]  wk_bits;
    logic [4:0]  mon_pos;
    logic [3:0]  wk_pos;
    logic        mon_hit, day_hit, wk_hit, sched_hit;
    logic [7:0]  hit_plan;
    logic        plan_ok;
    logic [3:0]  plan_m1;

    always_comb
    begin
        mon_bits  = sch_rdata[15:0];
        day_bits  = sch_rdata[47:16];
        wk_bits   = sch_rdata[55:48];
        mon_pos   = 5'(q_month_reg) + 5'd1;
        wk_pos    = 4'(q_wday_reg) + 4'd1;
        // month 15 and weekday 7 fall beyond their masks and never hit
        mon_hit   = (mon_pos < 5'd16) && mon_bits[mon_pos[3:0]];
        day_hit   = day_bits[q_mday_reg];
        wk_hit    = (wk_pos < 4'd8) && wk_bits[wk_pos[2:0]];
        sched_hit = mon_hit && (day_hit || wk_hit);
        hit_plan  = sch_rdata[63:56];
        plan_ok   = (hit_plan != '0) && (hit_plan <= 8'(DAY_PLANS));
        plan_m1   = 4'(hit_plan - 8'd1);
    end

    assign cmd_ready = (state_reg == S_IDLE);

    // clear on a taken query, then the slot read strobes
    assign slot_ctl = {cmd_valid && cmd_ready && (op_t'(op) == OP_QUERY),
                       slot_pend_reg, slot_last_reg};

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        sch_cnt_next    = sch_cnt_reg;
        sch_pend_next   = 1'b0;
        sch_last_next   = 1'b0;
        slot_cnt_next   = slot_cnt_reg;
        slot_pend_next  = 1'b0;
        slot_last_next  = 1'b0;
        base_next       = base_reg;
        q_month_next    = q_month_reg;
        q_mday_next     = q_mday_reg;
        q_wday_next     = q_wday_reg;
        now_next        = now_reg;
        res_status_next = res_status_reg;
        res_scheme_next = res_scheme_reg;
        res_plan_next   = res_plan_reg;
        res_action_next = res_action_reg;
        res_gap_next    = res_gap_reg;
        out_load        = 1'b0;

        sch_we     = 1'b0;
        sch_waddr  = '0;
        sch_wdata  = '0;
        sch_re     = 1'b0;
        sch_raddr  = sch_cnt_reg[SAW-1:0];
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        slot_re    = 1'b0;
        slot_raddr = base_reg + LAW'(slot_cnt_reg);
        act_we     = 1'b0;
        act_waddr  = '0;
        act_wdata  = '0;
        act_re     = 1'b0;
        act_raddr  = AAW'(slot_res.best_act - 8'd1);

        case (state_reg)
            S_CLEAR:
            begin
                // zero one row of every memory per cycle
                sch_we     = clr_cnt_reg < CW'(SCHEDULE_ENTRIES);
                sch_waddr  = clr_cnt_reg[SAW-1:0];
                slot_we    = clr_cnt_reg < CW'(SLOT_DEPTH);
                slot_waddr = clr_cnt_reg[LAW-1:0];
                act_we     = clr_cnt_reg < CW'(ACTION_COUNT);
                act_waddr  = clr_cnt_reg[AAW-1:0];
                if (clr_cnt_reg == CW'(CLEAR_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CW'(1);
                end
            end

            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    res_status_next = STAT_OK;
                    res_scheme_next = '0;
                    res_plan_next   = '0;
                    res_action_next = '0;
                    res_gap_next    = '0;
                    state_next      = S_RESULT;
                    case (op_t'(op))
                        OP_SCHED_WR:
                        begin
                            sch_we    = {1'b0, entry_index} < 9'(SCHEDULE_ENTRIES);
                            sch_waddr = entry_index[SAW-1:0];
                            sch_wdata = {id_value, week_mask, day_mask, month_mask};
                        end
                        OP_SLOT_WR:
                        begin
                            slot_we    = ({1'b0, table_index} < 5'(DAY_PLANS)) &&
                                         ({1'b0, entry_index} < 9'(SLOTS_PER_PLAN));
                            slot_waddr = LAW'(32'(table_index) * SLOTS_PER_PLAN +
                                              32'(entry_index));
                            slot_wdata = {id_value, hour, minute};
                        end
                        OP_ACT_WR:
                        begin
                            // action n lives at entry n-1
                            act_we    = (entry_index != '0) &&
                                        ({1'b0, entry_index} <= 9'(ACTION_COUNT));
                            act_waddr = AAW'(entry_index - 8'd1);
                            act_wdata = id_value;
                        end
                        OP_QUERY:
                        begin
                            q_month_next = month;
                            q_mday_next  = day_of_month;
                            q_wday_next  = weekday;
                            now_next     = minute_of_day(hour, minute);
                            sch_cnt_next = '0;
                            state_next   = S_SCHED;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            S_SCHED:
            begin
                // read ahead one entry per cycle, stop at the first hit
                if (sch_cnt_reg < SCW'(SCHEDULE_ENTRIES))
                begin
                    sch_re        = 1'b1;
                    sch_cnt_next  = sch_cnt_reg + SCW'(1);
                    sch_pend_next = 1'b1;
                    sch_last_next = (sch_cnt_reg == SCW'(SCHEDULE_ENTRIES - 1));
                end
                if (sch_pend_reg && sched_hit)
                begin
                    sch_pend_next = 1'b0;
                    if (plan_ok)
                    begin
                        base_next     = LAW'(32'(plan_m1) * SLOTS_PER_PLAN);
                        res_plan_next = hit_plan[4:0];
                        slot_cnt_next = '0;
                        state_next    = S_SLOT;
                    end
                    else
                    begin
                        res_status_next = STAT_NO_MATCH;
                        state_next      = S_RESULT;
                    end
                end
                else if (sch_pend_reg && sch_last_reg)
                begin
                    res_status_next = STAT_NO_MATCH;
                    state_next      = S_RESULT;
                end
            end

            S_SLOT:
            begin
                if (slot_cnt_reg < SLW'(SLOTS_PER_PLAN))
                begin
                    slot_re        = 1'b1;
                    slot_cnt_next  = slot_cnt_reg + SLW'(1);
                    slot_pend_next = 1'b1;
                    slot_last_next = (slot_cnt_reg == SLW'(SLOTS_PER_PLAN - 1));
                end
                if (slot_res.done)
                begin
                    state_next = S_ACT;
                end
            end

            S_ACT:
            begin
                if (!slot_res.any)
                begin
                    res_status_next = STAT_PLAN_EMPTY;
                    state_next      = S_RESULT;
                end
                else if ({1'b0, slot_res.best_act} > 9'(ACTION_COUNT))
                begin
                    res_status_next = STAT_BAD_ACTION;
                    res_action_next = slot_res.best_act;
                    res_gap_next    = slot_res.best_gap;
                    state_next      = S_RESULT;
                end
                else
                begin
                    act_re          = 1'b1;
                    res_status_next = STAT_OK;
                    res_action_next = slot_res.best_act;
                    res_gap_next    = slot_res.best_gap;
                    state_next      = S_ACT_DATA;
                end
            end

            S_ACT_DATA:
            begin
                res_scheme_next = act_rdata;
                state_next      = S_RESULT;
            end

            S_RESULT:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = out_load || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            sch_cnt_reg   <= '0;
            sch_pend_reg  <= 1'b0;
            sch_last_reg  <= 1'b0;
            slot_cnt_reg  <= '0;
            slot_pend_reg <= 1'b0;
            slot_last_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            sch_cnt_reg   <= sch_cnt_next;
            sch_pend_reg  <= sch_pend_next;
            sch_last_reg  <= sch_last_next;
            slot_cnt_reg  <= slot_cnt_next;
            slot_pend_reg <= slot_pend_next;
            slot_last_reg <= slot_last_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        q_month_reg    <= q_month_next;
        q_mday_reg     <= q_mday_next;
        q_wday_reg     <= q_wday_next;
        now_reg        <= now_next;
        res_status_reg <= res_status_next;
        res_scheme_reg <= res_scheme_next;
        res_plan_reg   <= res_plan_next;
        res_action_reg <= res_action_next;
        res_gap_reg    <= res_gap_next;
        if (out_load)
        begin
            status_reg <= res_status_reg;
            scheme_reg <= res_scheme_reg;
            plan_reg   <= res_plan_reg;
            action_reg <= res_action_reg;
            gap_reg    <= res_gap_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign scheme_id   = scheme_reg;
    assign plan_id     = plan_reg;
    assign action_id   = action_reg;
    assign gap_minutes = gap_reg;

    // schedule entries: month, day and weekday masks plus plan number
    dpss_ram #(
        .WIDTH(SCHED_W),
        .DEPTH(SCHEDULE_ENTRIES)
    ) u_sched_ram (
        .clk   (clk),
        .we    (sch_we),
        .waddr (sch_waddr),
        .wdata (sch_wdata),
        .re    (sch_re),
        .raddr (sch_raddr),
        .rdata (sch_rdata)
    );

    // plan slots: action, start hour and minute
    dpss_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(SLOT_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // action to scheme map
    dpss_ram #(
        .WIDTH(ACT_W),
        .DEPTH(ACTION_COUNT)
    ) u_act_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (act_wdata),
        .re    (act_re),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

    dpss_slot_pick u_slot_pick (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (slot_ctl),
        .rd_data (slot_rdata),
        .now     (now_reg),
        .res     (slot_res)
    );

endmodule
